// ----- rtl/normal_tail_probability_defines.svh -----
// Assertion macros shared by the normal tail probability RTL
`ifndef NORMAL_TAIL_PROBABILITY_DEFINES_SVH
`define NORMAL_TAIL_PROBABILITY_DEFINES_SVH
// property that must hold at every edge outside reset
`define NTP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define NTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/ntp_pkg.sv -----
// Package for the normal tail probability block: formats, constants and sequencer states
package ntp_pkg;
	localparam int TermCount  = 28;
	localparam int InFracBits = 26;
	localparam int CfBits     = 50;
	localparam int PrBits     = 62;
	localparam int OutBits    = 45;
	localparam int OutWidth   = 47;
	localparam int InWidth    = 32;

	localparam logic [63:0] PrOne       = 64'h4000_0000_0000_0000;
	localparam logic [63:0] PrHalf      = 64'h2000_0000_0000_0000;
	localparam logic [63:0] CfOne       = 64'h0004_0000_0000_0000;
	localparam logic [63:0] CfCap       = 64'h2000_0000_0000_0000;
	localparam logic [63:0] InvSqrt2PiQ62 = 64'd1839796536686825613;

	localparam logic [1:0] ActLower   = 2'd0;
	localparam logic [1:0] ActUpper   = 2'd1;
	localparam logic [1:0] ActCentral = 2'd2;

	// Serial multiplier: one multiplier bit per cycle, 64 steps
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,      // x55 = w*w >> 45
		ST_TMUL,    // term*y >> 62
		ST_TDIV,    // term / n
		ST_TACC,
		ST_PSQ,     // square sum eight times
		ST_DMUL,    // inv_sqrt_2pi * sum
		ST_SEL,
		ST_LCF,     // Laplace division
		ST_LFIN,
		ST_UU,
		ST_SCF,
		ST_SMUL,    // dn*w >> 50
		ST_SFIN,
		ST_MAP,
		ST_OUT
	} ntp_state_t;

	typedef enum logic [1:0] {
		DV_INT,     // integer quotient phase
		DV_FRAC,    // fraction bit phase
		DV_DONE
	} ntp_div_phase_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  shift;
		logic [63:0] cap;
	} ntp_div_req_t;
endpackage

// ----- rtl/normal_tail_probability.sv -----
// Processing time depends on whether |u| is above 3.7 or not;
// each nonpositive continued-fraction denominator on the central side skips its division.
// It comes from the bit-serial multiplier and the restoring divider (a Q50 quotient or an
// integer one) over 24 series terms, eight squarings and 29 divisions.
// One item at a time; the next is taken the cycle after the result beat has been delivered.
// Reset (arst_n, asynchronous) clears the sequencer and the output valid; no memories.
module normal_tail_probability #(
	parameter int TERM_COUNT   = ntp_pkg::TermCount,
	parameter int IN_FRAC_BITS = ntp_pkg::InFracBits
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ntp_pkg::InWidth-1:0] u_value,
	input  logic [1:0]                        action,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ntp_pkg::OutWidth-1:0] probability
);
	import ntp_pkg::*;

	localparam int TW = $clog2(TERM_COUNT + 1);

	ntp_state_t   state_q, state_d;
	logic [63:0]  wq_q, y_q, sum_q, term_q, dn_q, p_q, uu_q, p62_q;
	logic [4:0]   n_q;
	logic [3:0]   sq_q;
	logic [TW-1:0] t_q;
	logic         minus_q, neg_q, pos_q, tail_q, busy_q, out_valid_q;
	logic [1:0]   act_q;
	logic         issue_q;
	logic [OutWidth-1:0] prob_q;

	logic         mul_start, mul_done, div_done;
	logic [63:0]  mul_a, mul_b, mul_res, div_res;
	logic [6:0]   mul_sh;
	ntp_div_req_t div_req;

	logic [31:0]  uraw, wraw_in;
	logic [32:0]  wlim;
	logic [63:0]  d_lap;
	logic signed [64:0] d_sh, d_fin;
	logic signed [64:0] res;
	logic [63:0]  mag, r45, vout;

	assign wlim = 33'(16) << IN_FRAC_BITS;
	assign uraw = u_value;
	assign wraw_in = uraw[31] ? (32'd0 - uraw) : uraw;

	ntp_mul u_mul (
		.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b), .shift(mul_sh),
		.done(mul_done), .result(mul_res)
	);

	ntp_div u_div (.clk, .arst_n, .req(div_req), .done(div_done), .result(div_res));

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign busy_q   = (state_q != ST_IDLE);

	assign d_lap = wq_q + p_q;
	assign d_sh  = minus_q ? ($signed({1'b0, 64'(2 * t_q + 1) << CfBits}) - $signed({1'b0, p_q}))
	                       : ($signed({1'b0, 64'(2 * t_q + 1) << CfBits}) + $signed({1'b0, p_q}));
	assign d_fin = $signed({1'b0, CfOne}) - $signed({1'b0, p_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && in_ready) state_d = ST_SQ;
			ST_SQ:    if (mul_done) state_d = ST_TMUL;
			ST_TMUL:  if (mul_done) state_d = ST_TDIV;
			ST_TDIV:  if (div_done) state_d = ST_TACC;
			ST_TACC:  state_d = (n_q == 5'd24) ? ST_PSQ : ST_TMUL;
			ST_PSQ:   if (mul_done && sq_q == 4'd7) state_d = ST_DMUL;
			ST_DMUL:  if (mul_done) state_d = ST_SEL;
			ST_SEL:   state_d = tail_q ? ST_LCF : ST_UU;
			ST_LCF:   if (div_done && t_q == TW'(1)) state_d = ST_LFIN;
			ST_LFIN:  if (div_done) state_d = ST_MAP;
			ST_UU:    if (mul_done) state_d = ST_SCF;
			ST_SCF:   if ((div_done || (issue_q && !(d_sh > 0))) && t_q == TW'(1))
				state_d = ST_SMUL;
			ST_SMUL:  if (mul_done) state_d = ST_SFIN;
			ST_SFIN:  if (div_done || (issue_q && !(d_fin > 0))) state_d = ST_MAP;
			ST_MAP:   state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		mul_start     = 1'b0;
		mul_a         = wq_q;
		mul_b         = wq_q;
		mul_sh        = 7'd45;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		div_req.shift = 7'(CfBits);
		div_req.cap   = CfCap;
		case (state_q)
			ST_SQ:   mul_start = issue_q;
			ST_TMUL: begin
				mul_start = issue_q;
				mul_a     = term_q;
				mul_b     = y_q;
				mul_sh    = 7'(PrBits);
			end
			ST_TDIV: begin
				div_req.start = issue_q;
				div_req.num   = mul_res;
				div_req.den   = 64'(n_q);
				div_req.shift = '0;
				div_req.cap   = '1;
			end
			ST_PSQ: begin
				mul_start = issue_q;
				mul_a     = sum_q;
				mul_b     = sum_q;
				mul_sh    = 7'(PrBits);
			end
			ST_DMUL: begin
				mul_start = issue_q;
				mul_a     = InvSqrt2PiQ62;
				mul_b     = sum_q;
				mul_sh    = 7'(PrBits);
			end
			ST_LCF: begin
				div_req.start = issue_q;
				div_req.num   = 64'(t_q) << CfBits;
				div_req.den   = d_lap;
			end
			ST_LFIN: begin
				div_req.start = issue_q;
				div_req.num   = dn_q;
				div_req.den   = d_lap;
				div_req.cap   = PrHalf;
			end
			ST_UU: begin
				mul_start = issue_q;
				mul_sh    = 7'(CfBits);
			end
			ST_SCF: begin
				div_req.start = issue_q && (d_sh > 0);
				div_req.num   = 64'(t_q) * uu_q;
				div_req.den   = d_sh[63:0];
			end
			ST_SMUL: begin
				mul_start = issue_q;
				mul_a     = dn_q;
				mul_sh    = 7'(CfBits);
			end
			ST_SFIN: begin
				div_req.start = issue_q && (d_fin > 0);
				div_req.num   = mul_res;
				div_req.den   = d_fin[63:0];
				div_req.cap   = PrHalf;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// issue one unit request on entry and after each completion that stays
			issue_q <= (state_d != state_q) ||
			           ((state_q == ST_PSQ || state_q == ST_LCF) && (mul_done || div_done)) ||
			           (state_q == ST_SCF && (div_done || issue_q));
			if (state_q == ST_SCF && issue_q && d_sh > 0)
				issue_q <= 1'b0;
			if (state_q == ST_SFIN && issue_q && d_fin > 0)
				issue_q <= 1'b0;
			if (state_q == ST_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				neg_q  <= uraw[31];
				pos_q  <= !uraw[31] && (uraw != '0);
				act_q  <= action;
				tail_q <= (64'(wraw_in) * 64'd10) > (64'd37 << IN_FRAC_BITS);
				wq_q   <= 64'(wraw_in > wlim ? wlim : wraw_in) << (CfBits - IN_FRAC_BITS);
				sum_q  <= PrOne;
				term_q <= PrOne;
				n_q    <= 5'd1;
				sq_q   <= '0;
			end
			ST_SQ:   if (mul_done) y_q <= mul_res >> 2;
			ST_TDIV: if (div_done) term_q <= div_res;
			ST_TACC: begin
				sum_q <= n_q[0] ? sum_q - term_q : sum_q + term_q;
				n_q   <= n_q + 5'd1;
			end
			ST_PSQ: if (mul_done) begin
				sum_q <= mul_res;
				sq_q  <= sq_q + 4'd1;
			end
			ST_DMUL: if (mul_done) dn_q <= mul_res;
			ST_SEL: begin
				p_q     <= '0;
				t_q     <= TW'(TERM_COUNT);
				minus_q <= 1'b1;
			end
			ST_LCF: if (div_done) begin
				p_q <= div_res;
				t_q <= t_q - TW'(1);
			end
			ST_LFIN: if (div_done) p62_q <= div_res;
			ST_UU:   if (mul_done) uu_q <= mul_res;
			ST_SCF: begin
				if (issue_q && !(d_sh > 0)) begin
					p_q     <= CfCap;
					t_q     <= t_q - TW'(1);
					minus_q <= !minus_q;
				end else if (div_done) begin
					p_q     <= div_res;
					t_q     <= t_q - TW'(1);
					minus_q <= !minus_q;
				end
			end
			ST_SFIN: begin
				if (issue_q && !(d_fin > 0))
					p62_q <= PrHalf;
				else if (div_done)
					p62_q <= div_res;
			end
			ST_MAP:  prob_q <= vout[OutWidth-1:0];
			default: ;
		endcase
	end

	// map to the requested probability and round half away from zero to Q45
	always_comb begin
		if (tail_q) begin
			if (act_q[1])
				res = pos_q ? $signed({1'b0, PrHalf - p62_q}) : -$signed({1'b0, PrHalf - p62_q});
			else if ((pos_q && act_q == ActLower) || (neg_q && act_q == ActUpper))
				res = $signed({1'b0, PrOne - p62_q});
			else
				res = $signed({1'b0, p62_q});
		end else begin
			if (act_q[1])
				res = neg_q ? -$signed({1'b0, p62_q}) : $signed({1'b0, p62_q});
			else if ((pos_q && act_q == ActLower) || (neg_q && act_q == ActUpper))
				res = $signed({1'b0, PrHalf + p62_q});
			else
				res = $signed({1'b0, PrHalf - p62_q});
		end
		mag  = res[64] ? 64'(-res) : res[63:0];
		r45  = (mag + (64'd1 << (PrBits - OutBits - 1))) >> (PrBits - OutBits);
		vout = res[64] ? (64'd0 - r45) : r45;
	end

	assign out_valid   = out_valid_q;
	assign probability = prob_q;

	`include "normal_tail_probability_defines.svh"
	`NTP_ASSERT(a_no_accept_busy, !(in_valid && in_ready && busy_q), "item taken while busy")
	`NTP_ASSERT(a_one_request, !(mul_start && div_req.start), "two unit requests at once")
	`NTP_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(prob_q),
		"result beat dropped")
endmodule

// ----- rtl/ntp_mul.sv -----
// Bit-serial multiplier: floor(a*b >> s), saturated to all ones
module ntp_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [6:0]  shift,
	output logic        done,
	output logic [63:0] result
);
	import ntp_pkg::*;

	logic [127:0] acc_q;
	logic [127:0] mcand_q;
	logic [63:0]  mplier_q;
	logic [6:0]   cnt_q;
	logic [6:0]   sh_q;
	logic         busy_q;
	logic         done_q;
	logic [127:0] shifted;
	logic [127:0] hi_part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one bit of the multiplier per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {64'd0, a};
			mplier_q <= b;
			sh_q     <= shift;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[126:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[63:1]};
		end
	end

	always_comb begin
		shifted = acc_q >> sh_q;
		hi_part = acc_q >> (7'd64 + sh_q);
		result  = (hi_part != '0) ? '1 : shifted[63:0];
	end

	assign done = done_q;
endmodule

// ----- rtl/ntp_div.sv -----
// Restoring divider: floor(num * 2^s / den), capped; zero divisor gives the cap
module ntp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ntp_pkg::ntp_div_req_t req,
	output logic                  done,
	output logic [63:0]           result
);
	import ntp_pkg::*;

	ntp_div_phase_t phase_q;
	logic           busy_q;
	logic           done_q;
	logic [63:0]    den_q;
	logic [63:0]    cap_q;
	logic [6:0]     sh_q;
	logic [6:0]     cnt_q;
	logic [63:0]    num_q;
	logic [64:0]    rem_q;
	logic [63:0]    quo_q;
	logic           sat_q;
	logic [64:0]    rem_shift;
	logic [64:0]    diff;
	logic [63:0]    res_q;
	logic [64:0]    f2;
	logic [64:0]    fdiff;

	always_comb begin
		rem_shift = {rem_q[63:0], num_q[63]};
		diff      = rem_shift - {1'b0, den_q};
		f2        = {rem_q[63:0], 1'b0};
		fdiff     = f2 - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= DV_DONE;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= (req.den != '0);
				done_q  <= (req.den == '0);
				phase_q <= DV_INT;
				cnt_q   <= '0;
			end else if (busy_q) begin
				case (phase_q)
					DV_INT: begin
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd63) begin
							phase_q <= DV_FRAC;
							cnt_q   <= '0;
						end
					end
					DV_FRAC: begin
						cnt_q <= cnt_q + 7'd1;
						if (sat_q || cnt_q + 7'd1 >= sh_q || sh_q == '0) begin
							phase_q <= DV_DONE;
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	// integer quotient one bit a cycle, then fraction bits one a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			cap_q <= req.cap;
			sh_q  <= req.shift;
			num_q <= req.num;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			res_q <= req.cap;
		end else if (busy_q) begin
			case (phase_q)
				DV_INT: begin
					num_q <= {num_q[62:0], 1'b0};
					if (!diff[64]) begin
						rem_q <= diff;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_shift;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					if (cnt_q == 7'd63) begin
						if ({quo_q[62:0], !diff[64]} > (cap_q >> sh_q)) begin
							sat_q <= 1'b1;
							res_q <= cap_q;
						end else if (sh_q == '0) begin
							res_q <= {quo_q[62:0], !diff[64]};
						end
					end
				end
				DV_FRAC: begin
					if (!sat_q && sh_q != '0) begin
						if (!fdiff[64]) begin
							rem_q <= fdiff;
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= f2;
							quo_q <= {quo_q[62:0], 1'b0};
						end
						if (cnt_q + 7'd1 >= sh_q) begin
							if ({quo_q[62:0], !fdiff[64]} > cap_q)
								res_q <= cap_q;
							else
								res_q <= {quo_q[62:0], !fdiff[64]};
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`include "normal_tail_probability_defines.svh"
	`NTP_ASSERT(a_div_done_idle, !(done_q && busy_q), "divider done while busy")
	`NTP_ASSERT(a_div_cap, !done_q || res_q <= cap_q, "quotient above cap")
	`NTP_ASSERT_NEXT(a_div_start, req.start && req.den != '0, busy_q, "divider did not start")
endmodule
